// ----- rtl/ord_pkg.sv -----
`timescale 1ns / 1ps

package ord_pkg;

    localparam logic [7:0] STOP_BYTE = 8'h1a;
    localparam int unsigned HEADER_BYTES = 3;

    typedef enum logic [1:0] {
        PH_TYPE,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_BODY
    } phase_t;

    typedef enum logic [1:0] {
        ST_COMPLETE  = 2'd0,
        ST_TRUNCATED = 2'd1,
        ST_ZERO_LEN  = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0]  record_type;
        logic [15:0] payload_length;
        logic [7:0]  checksum_received;
        logic [7:0]  checksum_computed;
        logic        checksum_ok;
        status_t     status;
    } result_t;

endpackage

// ----- rtl/ord_parser.sv -----
`timescale 1ns / 1ps

module ord_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       data_byte,
    input  logic             end_of_file,
    output logic             res_valid,
    output ord_pkg::result_t res
);

    ord_pkg::phase_t phase_reg, phase_next;
    logic [7:0]      type_reg, type_next;
    logic [15:0]     length_reg, length_next;
    logic [15:0]     remaining_reg, remaining_next;
    logic [7:0]      sum_reg, sum_next;
    logic            halted_reg, halted_next;
    logic [7:0]      calc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ord_pkg::PH_TYPE;
            type_reg      <= '0;
            length_reg    <= '0;
            remaining_reg <= '0;
            sum_reg       <= '0;
            halted_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            type_reg      <= type_next;
            length_reg    <= length_next;
            remaining_reg <= remaining_next;
            sum_reg       <= sum_next;
            halted_reg    <= halted_next;
        end
    end

    // checksum byte itself is never added, so the emitted checksum is always the negation of sum_next
    assign calc = 8'(8'd0 - sum_next);

    always_comb
    begin
        phase_next     = phase_reg;
        type_next      = type_reg;
        length_next    = length_reg;
        remaining_next = remaining_reg;
        sum_next       = sum_reg;
        halted_next    = halted_reg;
        res_valid      = 1'b0;
        res.record_type       = type_reg;
        res.payload_length    = 16'(length_reg - 16'd1);
        res.checksum_received = 8'd0;
        res.checksum_computed = calc;
        res.checksum_ok       = 1'b0;
        res.status            = ord_pkg::ST_TRUNCATED;

        if (!halted_reg)
        begin
            unique case (phase_reg)
                ord_pkg::PH_LEN_LO:
                begin
                    length_next = {8'd0, data_byte};
                    sum_next    = 8'(sum_reg + data_byte);
                    phase_next  = ord_pkg::PH_LEN_HI;
                end
                ord_pkg::PH_LEN_HI:
                begin
                    length_next = {data_byte, length_reg[7:0]};
                    sum_next    = 8'(sum_reg + data_byte);
                    if (length_next == 16'd0)
                    begin
                        res_valid          = 1'b1;
                        res.payload_length = 16'd0;
                        res.status         = ord_pkg::ST_ZERO_LEN;
                        halted_next        = 1'b1;
                        phase_next         = ord_pkg::PH_TYPE;
                    end
                    else if (end_of_file)
                    begin
                        res_valid          = 1'b1;
                        res.payload_length = 16'(length_next - 16'd1);
                    end
                    else
                    begin
                        remaining_next = length_next;
                        phase_next     = ord_pkg::PH_BODY;
                    end
                end
                ord_pkg::PH_BODY:
                begin
                    if (remaining_reg <= 16'd1)
                    begin
                        res_valid             = 1'b1;
                        res.checksum_received = data_byte;
                        res.checksum_ok       = (calc == data_byte);
                        res.status            = ord_pkg::ST_COMPLETE;
                        remaining_next        = 16'd0;
                        phase_next            = ord_pkg::PH_TYPE;
                    end
                    else
                    begin
                        sum_next       = 8'(sum_reg + data_byte);
                        remaining_next = 16'(remaining_reg - 16'd1);
                        res_valid      = end_of_file;
                    end
                end
                default:
                begin
                    if (data_byte == ord_pkg::STOP_BYTE)
                        halted_next = 1'b1;
                    else
                    begin
                        type_next      = data_byte;
                        sum_next       = data_byte;
                        length_next    = 16'd0;
                        remaining_next = 16'd0;
                        phase_next     = ord_pkg::PH_LEN_LO;
                    end
                end
            endcase
        end

        // end of file rearms for the next file whatever happened
        if (end_of_file)
        begin
            halted_next    = 1'b0;
            phase_next     = ord_pkg::PH_TYPE;
            remaining_next = 16'd0;
        end
    end

endmodule

// ----- rtl/ord_out_stage.sv -----
`timescale 1ns / 1ps

module ord_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  ord_pkg::result_t res,
    output logic             free,
    output logic             out_valid,
    input  logic             out_ready,
    output ord_pkg::result_t out_res
);

    logic             valid_reg;
    ord_pkg::result_t res_reg;

    // a waiting result can be taken in the same cycle a new one is loaded
    assign free      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

endmodule

// ----- rtl/object_record_deframer.sv -----
`timescale 1ns / 1ps

// channel   | handshake                  | payload
// ----------+----------------------------+--------------------------------------------
// bytes in  | data_valid / data_ready    | data_byte, end_of_file
// records   | record_valid / record_ready| record_type, payload_length,
//           |                            | checksum_received, checksum_computed,
//           |                            | checksum_ok, status
//
// one byte per cycle; the record is loaded into the output register on the
// cycle its last byte (or cutting end of file) is accepted and shows in the next cycle
// data_ready drops only while a record waits and record_ready is low
// rst_n clears the parser phase, the halt flag and the output valid

module object_record_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_file,
    output logic        record_valid,
    input  logic        record_ready,
    output logic [7:0]  record_type,
    output logic [15:0] payload_length,
    output logic [7:0]  checksum_received,
    output logic [7:0]  checksum_computed,
    output logic        checksum_ok,
    output logic [1:0]  status
);

    logic             step;
    logic             res_valid;
    logic             free;
    ord_pkg::result_t res;
    ord_pkg::result_t out_res;

    assign data_ready = free;
    assign step       = data_valid && free;

    ord_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .data_byte   (data_byte),
        .end_of_file (end_of_file),
        .res_valid   (res_valid),
        .res         (res)
    );

    ord_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && res_valid),
        .res       (res),
        .free      (free),
        .out_valid (record_valid),
        .out_ready (record_ready),
        .out_res   (out_res)
    );

    assign record_type       = out_res.record_type;
    assign payload_length    = out_res.payload_length;
    assign checksum_received = out_res.checksum_received;
    assign checksum_computed = out_res.checksum_computed;
    assign checksum_ok       = out_res.checksum_ok;
    assign status            = out_res.status;

endmodule

// ----- rtl/ord_checker.sv -----
`timescale 1ns / 1ps

module ord_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        data_ready,
    input logic        record_valid,
    input logic        record_ready,
    input logic [7:0]  record_type,
    input logic [15:0] payload_length,
    input logic [7:0]  checksum_received,
    input logic [7:0]  checksum_computed,
    input logic        checksum_ok,
    input logic [1:0]  status
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        record_valid && !record_ready |=> record_valid && $stable(record_type)
            && $stable(payload_length) && $stable(status))
        else $error("record changed while stalled");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        record_valid |-> status != 2'd3)
        else $error("unknown status code");

    a_cut: assert property (@(posedge clk) disable iff (!rst_n)
        record_valid && status != ord_pkg::ST_COMPLETE |->
            !checksum_ok && checksum_received == 8'd0)
        else $error("cut off record carries checksum");

    a_ok: assert property (@(posedge clk) disable iff (!rst_n)
        record_valid && status == ord_pkg::ST_COMPLETE |->
            checksum_ok == (checksum_received == checksum_computed))
        else $error("checksum flag mismatch");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !record_valid |-> data_ready)
        else $error("input stalled with empty output");

endmodule

bind object_record_deframer ord_checker u_ord_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .data_ready        (data_ready),
    .record_valid      (record_valid),
    .record_ready      (record_ready),
    .record_type       (record_type),
    .payload_length    (payload_length),
    .checksum_received (checksum_received),
    .checksum_computed (checksum_computed),
    .checksum_ok       (checksum_ok),
    .status            (status)
);

// ----- verif/record_checker.sv -----
`timescale 1ns / 1ps

module record_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    input  logic        data_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_file,
    input  logic        record_valid,
    input  logic        record_ready,
    input  logic [7:0]  record_type,
    input  logic [15:0] payload_length,
    input  logic [7:0]  checksum_received,
    input  logic [7:0]  checksum_computed,
    input  logic        checksum_ok,
    input  logic [1:0]  status,
    output int          fail_count,
    output int          pending
);

    // parser shadow state
    ord_pkg::phase_t phase = ord_pkg::PH_TYPE;
    logic [7:0]      cur_type = '0;
    logic [15:0]     decl_len = '0;
    logic [15:0]     remaining = '0;
    logic [7:0]      byte_sum = '0;
    logic            halted = 1'b0;

    ord_pkg::result_t records_due[$];

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    task automatic flag_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
        $display("mismatch on %s: got %h, expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // one accepted byte through the parser; queues the record it closes, if any
    task automatic advance_parser(input logic [7:0] b, input logic eof);
        ord_pkg::result_t rec;
        logic             fire;
        fire = 1'b0;
        rec = '0;
        if (!halted)
        begin
            case (phase)
                ord_pkg::PH_LEN_LO:
                begin
                    decl_len = {8'h00, b};
                    byte_sum = byte_sum + b;
                    phase = ord_pkg::PH_LEN_HI;
                end
                ord_pkg::PH_LEN_HI:
                begin
                    decl_len[15:8] = b;
                    byte_sum = byte_sum + b;
                    if (decl_len == 16'h0000)
                    begin
                        fire = 1'b1;
                        rec.status = ord_pkg::ST_ZERO_LEN;
                        halted = 1'b1;
                        phase = ord_pkg::PH_TYPE;
                    end
                    else if (eof)
                    begin
                        fire = 1'b1;
                        rec.payload_length = decl_len - 16'd1;
                        rec.status = ord_pkg::ST_TRUNCATED;
                    end
                    else
                    begin
                        remaining = decl_len;
                        phase = ord_pkg::PH_BODY;
                    end
                end
                ord_pkg::PH_BODY:
                begin
                    if (remaining <= 16'd1)
                    begin
                        // checksum byte closes the record
                        fire = 1'b1;
                        rec.payload_length = decl_len - 16'd1;
                        rec.checksum_received = b;
                        rec.checksum_ok = (8'(8'h00 - byte_sum) == b);
                        rec.status = ord_pkg::ST_COMPLETE;
                        remaining = '0;
                        phase = ord_pkg::PH_TYPE;
                    end
                    else
                    begin
                        byte_sum = byte_sum + b;
                        remaining = remaining - 16'd1;
                        if (eof)
                        begin
                            fire = 1'b1;
                            rec.payload_length = decl_len - 16'd1;
                            rec.status = ord_pkg::ST_TRUNCATED;
                        end
                    end
                end
                default:
                begin
                    if (b == ord_pkg::STOP_BYTE)
                    begin
                        halted = 1'b1;
                    end
                    else
                    begin
                        cur_type = b;
                        byte_sum = b;
                        decl_len = '0;
                        remaining = '0;
                        phase = ord_pkg::PH_LEN_LO;
                    end
                end
            endcase
        end
        if (eof)
        begin
            halted = 1'b0;
            phase = ord_pkg::PH_TYPE;
            remaining = '0;
        end
        if (fire)
        begin
            rec.record_type = cur_type;
            rec.checksum_computed = 8'(8'h00 - byte_sum);
            records_due.push_back(rec);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        ord_pkg::result_t want;
        if (!rst_n)
        begin
            phase = ord_pkg::PH_TYPE;
            cur_type = '0;
            decl_len = '0;
            remaining = '0;
            byte_sum = '0;
            halted = 1'b0;
            records_due.delete();
        end
        else
        begin
            // results are registered before they leave, so compare first
            if (record_valid && record_ready)
            begin
                if (records_due.size() == 0)
                begin
                    flag_mismatch("record with none due", {8'h00, record_type}, 16'h0000);
                end
                else
                begin
                    want = records_due.pop_front();
                    if (record_type !== want.record_type)
                        flag_mismatch("record_type", {8'h00, record_type},
                                      {8'h00, want.record_type});
                    if (payload_length !== want.payload_length)
                        flag_mismatch("payload_length", payload_length, want.payload_length);
                    if (checksum_received !== want.checksum_received)
                        flag_mismatch("checksum_received", {8'h00, checksum_received},
                                      {8'h00, want.checksum_received});
                    if (checksum_computed !== want.checksum_computed)
                        flag_mismatch("checksum_computed", {8'h00, checksum_computed},
                                      {8'h00, want.checksum_computed});
                    if (checksum_ok !== want.checksum_ok)
                        flag_mismatch("checksum_ok", {15'h0000, checksum_ok},
                                      {15'h0000, want.checksum_ok});
                    if (status !== want.status)
                        flag_mismatch("status", {14'h0000, status}, {14'h0000, want.status});
                end
            end
            if (data_valid && data_ready)
                advance_parser(data_byte, end_of_file);
        end
        pending = records_due.size();
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int BYTE_COUNT = 1750;
    localparam int CALM_AFTER = 1550;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        data_valid = 1'b0;
    logic        data_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        end_of_file = 1'b0;
    logic        record_valid;
    logic        record_ready = 1'b0;
    logic [7:0]  record_type;
    logic [15:0] payload_length;
    logic [7:0]  checksum_received;
    logic [7:0]  checksum_computed;
    logic        checksum_ok;
    logic [1:0]  status;

    int fail_count;
    int pending;
    int bytes_sent = 0;
    int gap_pct = 20;
    int stall_pct = 20;
    bit quiet = 1'b0;

    object_record_deframer dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .data_valid        (data_valid),
        .data_ready        (data_ready),
        .data_byte         (data_byte),
        .end_of_file       (end_of_file),
        .record_valid      (record_valid),
        .record_ready      (record_ready),
        .record_type       (record_type),
        .payload_length    (payload_length),
        .checksum_received (checksum_received),
        .checksum_computed (checksum_computed),
        .checksum_ok       (checksum_ok),
        .status            (status)
    );

    record_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .data_valid        (data_valid),
        .data_ready        (data_ready),
        .data_byte         (data_byte),
        .end_of_file       (end_of_file),
        .record_valid      (record_valid),
        .record_ready      (record_ready),
        .record_type       (record_type),
        .payload_length    (payload_length),
        .checksum_received (checksum_received),
        .checksum_computed (checksum_computed),
        .checksum_ok       (checksum_ok),
        .status            (status),
        .fail_count        (fail_count),
        .pending           (pending)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // receiver stalls in bursts
    always
    begin
        @(posedge clk);
        if (!quiet && $urandom_range(0, 99) < stall_pct)
        begin
            record_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        record_ready <= 1'b1;
    end

    initial
    begin
        #1000000;
        $display("FAILURE");
        $finish;
    end

    function automatic int idle_rate();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 5;
            2: return 20;
            default: return 45;
        endcase
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // called at a rising edge; returns at the edge where the byte is taken
    task automatic send_byte(input logic [7:0] b, input logic eof);
        if (!quiet && $urandom_range(0, 99) < gap_pct)
        begin
            data_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        data_valid <= 1'b1;
        data_byte <= b;
        end_of_file <= eof;
        // ready is stable between the falling edge and the next rising edge
        @(negedge clk);
        while (!data_ready) @(negedge clk);
        @(posedge clk);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        data_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    task automatic send_junk(input int n);
        int i;
        for (i = 0; i < n; i++)
            send_byte(pick_byte(), i == n - 1);
    endtask

    // header, payload and checksum; end of file goes on byte eof_at and the
    // record stops there (negative means no end of file in this record)
    task automatic send_record(input logic [7:0] kind, input logic [15:0] len,
                               input bit good_sum, input int eof_at);
        logic [7:0] sum;
        logic [7:0] b;
        int         total;
        int         idx;
        total = int'(len) + int'(ord_pkg::HEADER_BYTES);
        sum = 8'h00;
        for (idx = 0; idx < total; idx++)
        begin
            if (idx == 0)
                b = kind;
            else if (idx == 1)
                b = len[7:0];
            else if (idx == 2)
                b = len[15:8];
            else if (idx == total - 1)
                b = good_sum ? 8'(8'h00 - sum) : 8'(8'h00 - sum + 8'($urandom_range(1, 255)));
            else
                b = pick_byte();
            sum = sum + b;
            send_byte(b, idx == eof_at);
            if (idx == eof_at)
                break;
        end
    endtask

    task automatic send_file();
        int          nrec;
        int          r;
        int          total;
        int          cut;
        logic [7:0]  kind;
        logic [15:0] len;
        gap_pct = idle_rate();
        stall_pct = idle_rate();
        nrec = $urandom_range(1, 4);
        for (r = 0; r < nrec; r++)
        begin
            kind = pick_byte();
            case ($urandom_range(0, 15))
                0:
                begin
                    send_byte(ord_pkg::STOP_BYTE, 1'b0);
                    send_junk($urandom_range(1, 6));
                    return;
                end
                1:
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        send_record(kind, 16'h0000, 1'b1, 2);
                    end
                    else
                    begin
                        send_record(kind, 16'h0000, 1'b1, -1);
                        send_junk($urandom_range(1, 6));
                    end
                    return;
                end
                2:
                begin
                    // long declared length, always cut short
                    len = 16'($urandom_range(41, 65535));
                    send_record(kind, len, 1'b1, $urandom_range(2, 10));
                    return;
                end
                default:
                begin
                    if ($urandom_range(0, 3) == 0)
                        len = 16'($urandom_range(9, 40));
                    else
                        len = 16'($urandom_range(1, 8));
                    total = int'(len) + int'(ord_pkg::HEADER_BYTES);
                    if (r < nrec - 1)
                        cut = -1;
                    else if ($urandom_range(0, 3) != 0)
                        cut = total - 1;
                    else
                        cut = $urandom_range(0, total - 1);
                    send_record(kind, len, $urandom_range(0, 1), cut);
                end
            endcase
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes and each special case
        send_record(8'h00, 16'h0001, 1'b1, 3);       // checksum only, eof on it
        send_record(8'hff, 16'h0002, 1'b0, 4);       // bad checksum
        send_byte(ord_pkg::STOP_BYTE, 1'b1);         // stop marker with eof
        send_record(8'h55, 16'hffff, 1'b1, 2);       // eof on high length byte
        send_record(8'haa, 16'h0000, 1'b1, -1);      // zero length, then halted
        send_junk(2);
        send_record(8'h01, 16'h0004, 1'b1, 0);       // eof on type byte
        send_record(8'h02, 16'h0004, 1'b1, 1);       // eof on low length byte
        send_record(8'h80, 16'h8000, 1'b1, 4);       // cut inside payload
        wait_drained();

        while (bytes_sent < BYTE_COUNT)
        begin
            if (bytes_sent >= CALM_AFTER)
                quiet = 1'b1;
            send_file();
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ord_pkg.sv
rtl/ord_parser.sv
rtl/ord_out_stage.sv
rtl/object_record_deframer.sv
rtl/ord_checker.sv
verif/record_checker.sv
verif/testbench.sv
